[rtl/rtu_pkg.sv]
`default_nettype none

package rtu_pkg;

    // Number format and datapath widths.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    // Up to four products of two 32-bit operands plus rounding need 66 bits; two spare.
    localparam int ACC_W     = PROD_W + 4;

    // Matrix geometry: 3 rows by 4 columns, addressed as {row, col}.
    localparam int N_ROWS    = 3;
    localparam int N_ELEMS   = 12;
    localparam int IDX_W     = 2;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int STEP_W    = 4;
    localparam int N_MINORS  = 3;

    localparam logic [IDX_W-1:0] LAST_ROW  = IDX_W'(N_ROWS - 1);
    localparam logic [IDX_W-1:0] TRANS_COL = IDX_W'(3);

    localparam logic signed [DATA_W-1:0] ONE_Q    = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  SAT_MAX  = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0]  SAT_MIN  = -(ACC_W'(1) << (DATA_W - 1));

    typedef enum logic [2:0] {
        OP_LOAD_A      = 3'd0,
        OP_LOAD_B      = 3'd1,
        OP_COMPOSE     = 3'd2,
        OP_INVERSE     = 3'd3,
        OP_DETERMINANT = 3'd4,
        OP_DESCALE     = 3'd5
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // Source of the second multiplier operand.
    typedef enum logic [2:0] {
        Y_A,
        Y_B,
        Y_ONE,
        Y_SCALE,
        Y_MINOR
    } ysel_t;

    // Control word that travels with each product through the MAC pipeline.
    typedef struct packed {
        logic             valid;
        logic             sub;
        logic             first;
        logic             fin;
        logic             to_minor;
        logic [1:0]       minor_idx;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/rtu_chan_if.sv]
`default_nettype none

interface rtu_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  operation;
    logic [1:0]                  row_index;
    logic [1:0]                  col_index;
    logic signed [31:0]          value;

    modport source (output valid, output operation, output row_index, output col_index,
                    output value, input ready);
    modport sink   (input valid, input operation, input row_index, input col_index,
                    input value, output ready);
endinterface

interface rtu_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  out_row;
    logic [1:0]                  out_col;
    logic signed [31:0]          out_value;
    logic                        last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/rtu_ram.sv]
`default_nettype none

module rtu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/rtu_mac.sv]
`default_nettype none

// Shared multiply-accumulate unit: product register, accumulator register, then
// rounding to nearest (ties up) and saturation to 32 bits on the accumulator output.
module rtu_mac (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire rtu_pkg::mac_ctrl_t                in_ctrl,
    input  wire logic signed [rtu_pkg::DATA_W-1:0] x,
    input  wire logic signed [rtu_pkg::DATA_W-1:0] y,
    output      rtu_pkg::mac_ctrl_t                out_ctrl,
    output      logic signed [rtu_pkg::DATA_W-1:0] result
);

    rtu_pkg::mac_ctrl_t                 prod_ctrl_reg;
    rtu_pkg::mac_ctrl_t                 acc_ctrl_reg;
    logic signed [rtu_pkg::PROD_W-1:0]  prod_reg;
    logic signed [rtu_pkg::PROD_W-1:0]  prod_next;
    logic signed [rtu_pkg::ACC_W-1:0]   acc_reg;
    logic signed [rtu_pkg::ACC_W-1:0]   acc_next;
    logic signed [rtu_pkg::ACC_W-1:0]   acc_base;
    logic signed [rtu_pkg::ACC_W-1:0]   prod_ext;
    logic signed [rtu_pkg::ACC_W-1:0]   rounded;
    logic signed [rtu_pkg::ACC_W-1:0]   shifted;

    assign prod_next = x * y;

    always_comb
    begin
        prod_ext = rtu_pkg::ACC_W'(prod_reg);
        acc_base = prod_ctrl_reg.first ? '0 : acc_reg;
        if (prod_ctrl_reg.sub)
        begin
            acc_next = acc_base - prod_ext;
        end
        else
        begin
            acc_next = acc_base + prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctrl_reg <= '0;
            acc_ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            prod_ctrl_reg <= in_ctrl;
            acc_ctrl_reg  <= prod_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            if (prod_ctrl_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_comb
    begin
        rounded = acc_reg + rtu_pkg::ACC_HALF;
        shifted = rounded >>> rtu_pkg::FRAC_BITS;
        if (shifted > rtu_pkg::SAT_MAX)
        begin
            result = rtu_pkg::DATA_W'(rtu_pkg::SAT_MAX);
        end
        else if (shifted < rtu_pkg::SAT_MIN)
        begin
            result = rtu_pkg::DATA_W'(rtu_pkg::SAT_MIN);
        end
        else
        begin
            result = shifted[rtu_pkg::DATA_W-1:0];
        end
    end

    assign out_ctrl = acc_ctrl_reg;

endmodule

`default_nettype wire

[rtl/rigid_transform_unit.sv]
`default_nettype none

// Channel  Dir  Fields                                        Transfer when
// -------  ---  --------------------------------------------  -------------------
// cmd      in   operation, row_index, col_index, value        cmd.valid & cmd.ready
// rsp      out  out_row, out_col, out_value, last             rsp.valid & rsp.ready
//
// A run item issues one product per cycle into the shared MAC unless stalled, so its product
// count sets the cost: compose 39 products, inverse 18, determinant 9, descale 12. cmd.ready
// rises again once the sequencer is idle and the operand stage is empty, while the last
// element still passes the MAC registers. Reset (rst_n, asynchronous, active low) clears
// the sequencer and pipeline valid bits; matrix contents are undefined until loaded. While
// a result waits in the output register with rsp.ready low, the whole pipeline holds.
module rigid_transform_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rtu_cmd_if.sink    cmd,
    rtu_rsp_if.source  rsp
);

    // Global advance: every pipeline register moves only when the output register
    // is free or being emptied in this cycle.
    logic adv;

    logic cmd_fire;
    rtu_pkg::op_t cmd_op;

    // Sequencer state.
    rtu_pkg::seq_state_t                 state_reg, state_next;
    rtu_pkg::op_t                        op_reg, op_next;
    logic [rtu_pkg::IDX_W-1:0]           i_reg, i_next;
    logic [rtu_pkg::IDX_W-1:0]           j_reg, j_next;
    logic [rtu_pkg::STEP_W-1:0]          t_reg, t_next;
    logic signed [rtu_pkg::DATA_W-1:0]   scale_reg, scale_next;

    // Decoded product for the current step.
    rtu_pkg::mac_ctrl_t                  iss_ctrl;
    rtu_pkg::ysel_t                      iss_ysel;
    logic [rtu_pkg::ADDR_W-1:0]          iss_xaddr;
    logic [rtu_pkg::ADDR_W-1:0]          iss_yaddr;
    logic                                term_last;
    logic                                elem_last;

    // Operand stage, aligned with the registered RAM read data.
    rtu_pkg::mac_ctrl_t                  p1_ctrl_reg;
    rtu_pkg::ysel_t                      p1_ysel_reg;
    logic signed [rtu_pkg::DATA_W-1:0]   op_x;
    logic signed [rtu_pkg::DATA_W-1:0]   op_y;

    logic [rtu_pkg::DATA_W-1:0]          a_x_rdata;
    logic [rtu_pkg::DATA_W-1:0]          a_y_rdata;
    logic [rtu_pkg::DATA_W-1:0]          b_y_rdata;
    logic                                we_a;
    logic                                we_b;
    logic [rtu_pkg::ADDR_W-1:0]          waddr;

    // 2x2 minors of the determinant, rounded and saturated.
    logic signed [rtu_pkg::DATA_W-1:0]   minor_reg [rtu_pkg::N_MINORS];

    rtu_pkg::mac_ctrl_t                  mac_ctrl;
    logic signed [rtu_pkg::DATA_W-1:0]   mac_result;
    logic                                res_out;
    logic                                res_minor;

    // Output register.
    logic                                out_valid_reg, out_valid_next;
    logic [rtu_pkg::IDX_W-1:0]           out_row_reg;
    logic [rtu_pkg::IDX_W-1:0]           out_col_reg;
    logic signed [rtu_pkg::DATA_W-1:0]   out_value_reg;
    logic                                out_last_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == rtu_pkg::ST_IDLE) && !p1_ctrl_reg.valid;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd_op    = rtu_pkg::op_t'(cmd.operation);

    // Loads: A is kept in two copies so that two A elements can be read per cycle.
    // A load aimed at a row beyond the matrix is dropped.
    assign waddr = {cmd.row_index, cmd.col_index};
    assign we_a  = cmd_fire && (cmd_op == rtu_pkg::OP_LOAD_A)
                   && (cmd.row_index <= rtu_pkg::LAST_ROW);
    assign we_b  = cmd_fire && (cmd_op == rtu_pkg::OP_LOAD_B)
                   && (cmd.row_index <= rtu_pkg::LAST_ROW);

    rtu_ram #(.WIDTH(rtu_pkg::DATA_W), .DEPTH(rtu_pkg::N_ELEMS)) u_ram_a_x (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (cmd.value),
        .re    (adv),
        .raddr (iss_xaddr),
        .rdata (a_x_rdata)
    );

    rtu_ram #(.WIDTH(rtu_pkg::DATA_W), .DEPTH(rtu_pkg::N_ELEMS)) u_ram_a_y (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (cmd.value),
        .re    (adv),
        .raddr (iss_yaddr),
        .rdata (a_y_rdata)
    );

    rtu_ram #(.WIDTH(rtu_pkg::DATA_W), .DEPTH(rtu_pkg::N_ELEMS)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (cmd.value),
        .re    (adv),
        .raddr (iss_yaddr),
        .rdata (b_y_rdata)
    );

    // Step decoder. Every result element is a sum of products; elements that are
    // copied or offset by A's translation use the constant one as a multiplier, so
    // the translation enters exactly and a copy passes through unchanged.
    always_comb
    begin
        iss_ctrl          = '0;
        iss_ctrl.valid    = (state_reg == rtu_pkg::ST_RUN);
        iss_ctrl.row      = i_reg;
        iss_ctrl.col      = j_reg;
        iss_ysel          = rtu_pkg::Y_ONE;
        iss_xaddr         = {i_reg, j_reg};
        iss_yaddr         = {i_reg, j_reg};
        term_last         = 1'b1;
        elem_last         = (i_reg == rtu_pkg::LAST_ROW) && (j_reg == rtu_pkg::TRANS_COL);

        unique case (op_reg)
            rtu_pkg::OP_COMPOSE:
            begin
                iss_ctrl.first = (t_reg == '0);
                if (t_reg == rtu_pkg::STEP_W'(3))
                begin
                    // Translation of A added at full precision.
                    iss_xaddr = {i_reg, rtu_pkg::TRANS_COL};
                    iss_ysel  = rtu_pkg::Y_ONE;
                    term_last = 1'b1;
                end
                else
                begin
                    iss_xaddr = {i_reg, t_reg[rtu_pkg::IDX_W-1:0]};
                    iss_yaddr = {t_reg[rtu_pkg::IDX_W-1:0], j_reg};
                    iss_ysel  = rtu_pkg::Y_B;
                    term_last = (j_reg == rtu_pkg::TRANS_COL) ? 1'b0
                              : (t_reg == rtu_pkg::STEP_W'(2));
                end
            end
            rtu_pkg::OP_INVERSE:
            begin
                if (j_reg == rtu_pkg::TRANS_COL)
                begin
                    // Back-rotated translation, negated: subtract each product.
                    iss_ctrl.first = (t_reg == '0);
                    iss_ctrl.sub   = 1'b1;
                    iss_xaddr      = {t_reg[rtu_pkg::IDX_W-1:0], i_reg};
                    iss_yaddr      = {t_reg[rtu_pkg::IDX_W-1:0], rtu_pkg::TRANS_COL};
                    iss_ysel       = rtu_pkg::Y_A;
                    term_last      = (t_reg == rtu_pkg::STEP_W'(2));
                end
                else
                begin
                    iss_ctrl.first = 1'b1;
                    iss_xaddr      = {j_reg, i_reg};
                end
            end
            rtu_pkg::OP_DESCALE:
            begin
                iss_ctrl.first = 1'b1;
                if (j_reg == rtu_pkg::TRANS_COL)
                begin
                    iss_ysel = rtu_pkg::Y_SCALE;
                end
            end
            rtu_pkg::OP_DETERMINANT:
            begin
                // Three minors first, then expansion along column 0. A minor's last
                // product leaves the accumulator before the expansion step reads it.
                iss_ctrl.row = '0;
                iss_ctrl.col = '0;
                elem_last    = 1'b1;
                term_last    = 1'b0;
                iss_ysel     = rtu_pkg::Y_A;
                case (t_reg)
                    4'd0:
                    begin
                        iss_ctrl.first = 1'b1;
                        iss_xaddr      = {2'd1, 2'd1};
                        iss_yaddr      = {2'd2, 2'd2};
                    end
                    4'd1:
                    begin
                        iss_ctrl.sub       = 1'b1;
                        iss_ctrl.fin       = 1'b1;
                        iss_ctrl.to_minor  = 1'b1;
                        iss_ctrl.minor_idx = 2'd0;
                        iss_xaddr          = {2'd2, 2'd1};
                        iss_yaddr          = {2'd1, 2'd2};
                    end
                    4'd2:
                    begin
                        iss_ctrl.first = 1'b1;
                        iss_xaddr      = {2'd0, 2'd1};
                        iss_yaddr      = {2'd2, 2'd2};
                    end
                    4'd3:
                    begin
                        iss_ctrl.sub       = 1'b1;
                        iss_ctrl.fin       = 1'b1;
                        iss_ctrl.to_minor  = 1'b1;
                        iss_ctrl.minor_idx = 2'd1;
                        iss_xaddr          = {2'd0, 2'd2};
                        iss_yaddr          = {2'd2, 2'd1};
                    end
                    4'd4:
                    begin
                        iss_ctrl.first = 1'b1;
                        iss_xaddr      = {2'd0, 2'd1};
                        iss_yaddr      = {2'd1, 2'd2};
                    end
                    4'd5:
                    begin
                        iss_ctrl.sub       = 1'b1;
                        iss_ctrl.fin       = 1'b1;
                        iss_ctrl.to_minor  = 1'b1;
                        iss_ctrl.minor_idx = 2'd2;
                        iss_xaddr          = {2'd0, 2'd2};
                        iss_yaddr          = {2'd1, 2'd1};
                    end
                    4'd6:
                    begin
                        iss_ctrl.first     = 1'b1;
                        iss_ctrl.minor_idx = 2'd0;
                        iss_xaddr          = {2'd0, 2'd0};
                        iss_ysel           = rtu_pkg::Y_MINOR;
                    end
                    4'd7:
                    begin
                        iss_ctrl.sub       = 1'b1;
                        iss_ctrl.minor_idx = 2'd1;
                        iss_xaddr          = {2'd1, 2'd0};
                        iss_ysel           = rtu_pkg::Y_MINOR;
                    end
                    default:
                    begin
                        iss_ctrl.minor_idx = 2'd2;
                        iss_xaddr          = {2'd2, 2'd0};
                        iss_ysel           = rtu_pkg::Y_MINOR;
                        term_last          = 1'b1;
                    end
                endcase
            end
            default:
            begin
                iss_ctrl.valid = 1'b0;
            end
        endcase

        if (term_last)
        begin
            iss_ctrl.fin = 1'b1;
        end
        iss_ctrl.last = term_last && elem_last;
    end

    // Sequencer: accepts items while idle and walks the steps of a run item.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        scale_next = scale_reg;

        unique case (state_reg)
            rtu_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd_op) inside
                        rtu_pkg::OP_COMPOSE, rtu_pkg::OP_INVERSE,
                        rtu_pkg::OP_DETERMINANT, rtu_pkg::OP_DESCALE:
                        begin
                            state_next = rtu_pkg::ST_RUN;
                            op_next    = cmd_op;
                            i_next     = '0;
                            j_next     = '0;
                            t_next     = '0;
                            if (cmd_op == rtu_pkg::OP_DESCALE)
                            begin
                                scale_next = cmd.value;
                            end
                        end
                        default:
                        begin
                            // Loads and unknown codes start nothing.
                        end
                    endcase
                end
            end
            rtu_pkg::ST_RUN:
            begin
                if (adv)
                begin
                    if (!term_last)
                    begin
                        t_next = t_reg + rtu_pkg::STEP_W'(1);
                    end
                    else
                    begin
                        t_next = '0;
                        if (elem_last)
                        begin
                            state_next = rtu_pkg::ST_IDLE;
                        end
                        else if (j_reg == rtu_pkg::TRANS_COL)
                        begin
                            j_next = '0;
                            i_next = i_reg + rtu_pkg::IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + rtu_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = rtu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rtu_pkg::ST_IDLE;
            op_reg      <= rtu_pkg::OP_LOAD_A;
            i_reg       <= '0;
            j_reg       <= '0;
            t_reg       <= '0;
            p1_ctrl_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            t_reg     <= t_next;
            if (adv)
            begin
                p1_ctrl_reg <= iss_ctrl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        if (adv)
        begin
            p1_ysel_reg <= iss_ysel;
        end
    end

    // Operand selection for the multiplier.
    always_comb
    begin
        op_x = a_x_rdata;
        unique case (p1_ysel_reg)
            rtu_pkg::Y_A:     op_y = a_y_rdata;
            rtu_pkg::Y_B:     op_y = b_y_rdata;
            rtu_pkg::Y_SCALE: op_y = scale_reg;
            rtu_pkg::Y_MINOR: op_y = minor_reg[p1_ctrl_reg.minor_idx];
            default:          op_y = rtu_pkg::ONE_Q;
        endcase
    end

    rtu_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctrl  (p1_ctrl_reg),
        .x        (op_x),
        .y        (op_y),
        .out_ctrl (mac_ctrl),
        .result   (mac_result)
    );

    assign res_out   = adv && mac_ctrl.valid && mac_ctrl.fin && !mac_ctrl.to_minor;
    assign res_minor = adv && mac_ctrl.valid && mac_ctrl.fin && mac_ctrl.to_minor;

    always_ff @(posedge clk)
    begin
        if (res_minor)
        begin
            minor_reg[mac_ctrl.minor_idx] <= mac_result;
        end
    end

    // Output register: a finished element is held here until its transfer.
    always_comb
    begin
        if (res_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_out)
        begin
            out_row_reg   <= mac_ctrl.row;
            out_col_reg   <= mac_ctrl.col;
            out_value_reg <= mac_result;
            out_last_reg  <= mac_ctrl.last;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_row   = out_row_reg;
    assign rsp.out_col   = out_col_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.last      = out_last_reg;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for rigid_transform_unit.
//
// Commands go in on the cmd channel and the emitted matrix elements come back on the
// rsp channel. A predictor inside this module keeps its own copy of both transforms.
// It works out, for every command transfer, the elements that the block must emit.
// Those elements wait in a queue until the matching result transfers arrive. A
// checker process compares every result transfer, field by field, with the oldest
// element in that queue.
//
// Both matrices are loaded completely before the first run command. This way no
// operation ever reads an element that was never written since reset.
module tb;

    // Commands 6 and 7 are not defined. The block must accept and drop them.
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    localparam int ROW_STRIDE    = 4;
    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLD_CYCLES   = 300;
    // Covers the longest run, compose: its issue steps plus the pipeline drain, with margin.
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 100;
    localparam int TIMEOUT       = 8 * 500000;

    typedef logic signed [95:0] wide_t;

    typedef struct {
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
        logic               last;
    } elem_t;

    localparam logic signed [31:0] DIRECTED_A [12] = '{
        32'sh7FFF_FFFF, 32'sh0000_8000, 32'shFFFF_0000, 32'sh8000_0000,
        32'sh8000_0000, 32'sh0001_0000, 32'sh0000_0001, 32'sh0003_2000,
        32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_B505, 32'sh7FFF_FFFF
    };
    localparam logic signed [31:0] DIRECTED_B [12] = '{
        32'sh0000_0000, 32'shFFFF_0000, 32'sh0000_0000, 32'sh0001_8000,
        32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 32'shFFFE_0000,
        32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000, 32'sh0000_4000
    };

    logic clk;
    logic rst_n;

    rtu_cmd_if cmd_ch ();
    rtu_rsp_if rsp_ch ();

    rigid_transform_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // These are the predictor's copies of the two transforms, in row-major order.
    logic signed [31:0] xform_a [12];
    logic signed [31:0] xform_b [12];

    elem_t pending_elements [$];
    int    error_count;
    // When this bit is clear, neither side inserts idle cycles.
    bit    idle_enable;
    // A nonzero value asks the result receiver for one long stall.
    int    rsp_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // This is the hard limit on the run. A hang of the block ends here.
    initial
    begin
        #(TIMEOUT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Arithmetic of the predictor
    // ------------------------------------------------------------------

    function automatic wide_t widen(logic signed [31:0] v);
        return v;
    endfunction

    function automatic wide_t mul_q(logic signed [31:0] x, logic signed [31:0] y);
        return widen(x) * widen(y);
    endfunction

    // The sum has been formed exactly. It is now rounded to nearest, with ties going
    // toward plus infinity, and then saturated to 32 bits.
    function automatic logic signed [31:0] round_q(wide_t s);
        wide_t r;
        r = (s + (wide_t'(1) <<< (rtu_pkg::FRAC_BITS - 1))) >>> rtu_pkg::FRAC_BITS;
        if (r > widen(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (r < widen(32'sh8000_0000))
            return 32'sh8000_0000;
        return r[31:0];
    endfunction

    function automatic int at(int r, int c);
        return r * ROW_STRIDE + c;
    endfunction

    task automatic push_element(int r, int c, logic signed [31:0] v, logic last);
        elem_t e;
        e.row   = 2'(r);
        e.col   = 2'(c);
        e.value = v;
        e.last  = last;
        pending_elements.push_back(e);
    endtask

    // This task updates the stored transforms for one accepted command. It also
    // queues every element that the command must produce.
    task automatic predict_transform(logic [2:0] op, logic [1:0] row, logic [1:0] col,
                                     logic signed [31:0] val);
        wide_t              acc;
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] m2;
        logic signed [31:0] v;
        int                 i;
        int                 j;
        int                 r;
        case (op)
            rtu_pkg::OP_LOAD_A:
            begin
                // A load aimed at the nonexistent fourth row is dropped.
                if (row <= rtu_pkg::LAST_ROW)
                    xform_a[at(row, col)] = val;
            end
            rtu_pkg::OP_LOAD_B:
            begin
                if (row <= rtu_pkg::LAST_ROW)
                    xform_b[at(row, col)] = val;
            end
            rtu_pkg::OP_COMPOSE:
            begin
                for (i = 0; i < rtu_pkg::N_ROWS; i++)
                begin
                    for (j = 0; j <= rtu_pkg::TRANS_COL; j++)
                    begin
                        // The translation column also takes A's own translation,
                        // which enters the sum exactly.
                        acc = (j == rtu_pkg::TRANS_COL)
                            ? (widen(xform_a[at(i, rtu_pkg::TRANS_COL)])
                               <<< rtu_pkg::FRAC_BITS)
                            : wide_t'(0);
                        for (r = 0; r < rtu_pkg::N_ROWS; r++)
                            acc += mul_q(xform_a[at(i, r)], xform_b[at(r, j)]);
                        push_element(i, j, round_q(acc),
                                     i == rtu_pkg::LAST_ROW && j == rtu_pkg::TRANS_COL);
                    end
                end
            end
            rtu_pkg::OP_INVERSE:
            begin
                for (i = 0; i < rtu_pkg::N_ROWS; i++)
                begin
                    for (j = 0; j <= rtu_pkg::TRANS_COL; j++)
                    begin
                        if (j < rtu_pkg::TRANS_COL)
                        begin
                            v = xform_a[at(j, i)];
                        end
                        else
                        begin
                            acc = 0;
                            for (r = 0; r < rtu_pkg::N_ROWS; r++)
                                acc -= mul_q(xform_a[at(r, i)],
                                             xform_a[at(r, rtu_pkg::TRANS_COL)]);
                            v = round_q(acc);
                        end
                        push_element(i, j, v,
                                     i == rtu_pkg::LAST_ROW && j == rtu_pkg::TRANS_COL);
                    end
                end
            end
            rtu_pkg::OP_DETERMINANT:
            begin
                // The expansion runs along column 0. Each 2x2 minor is rounded and
                // saturated on its own before the final sum is formed.
                m0 = round_q(mul_q(xform_a[at(1, 1)], xform_a[at(2, 2)])
                           - mul_q(xform_a[at(2, 1)], xform_a[at(1, 2)]));
                m1 = round_q(mul_q(xform_a[at(0, 1)], xform_a[at(2, 2)])
                           - mul_q(xform_a[at(0, 2)], xform_a[at(2, 1)]));
                m2 = round_q(mul_q(xform_a[at(0, 1)], xform_a[at(1, 2)])
                           - mul_q(xform_a[at(0, 2)], xform_a[at(1, 1)]));
                acc = mul_q(xform_a[at(0, 0)], m0) - mul_q(xform_a[at(1, 0)], m1)
                    + mul_q(xform_a[at(2, 0)], m2);
                push_element(0, 0, round_q(acc), 1'b1);
            end
            rtu_pkg::OP_DESCALE:
            begin
                for (i = 0; i < rtu_pkg::N_ROWS; i++)
                begin
                    for (j = 0; j <= rtu_pkg::TRANS_COL; j++)
                    begin
                        if (j < rtu_pkg::TRANS_COL)
                            v = xform_a[at(i, j)];
                        else
                            v = round_q(mul_q(xform_a[at(i, rtu_pkg::TRANS_COL)], val));
                        push_element(i, j, v,
                                     i == rtu_pkg::LAST_ROW && j == rtu_pkg::TRANS_COL);
                    end
                end
            end
            default:
            begin
                // Undefined commands change nothing and emit nothing.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_error(string msg);
        if (error_count < MAX_REPORTS)
            $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_element();
        elem_t want;
        if (pending_elements.size() == 0)
        begin
            report_error($sformatf("unexpected result row %0d col %0d value %0d last %0d",
                                   rsp_ch.out_row, rsp_ch.out_col, rsp_ch.out_value,
                                   rsp_ch.last));
        end
        else
        begin
            want = pending_elements.pop_front();
            if (rsp_ch.out_row !== want.row)
                report_error($sformatf("out_row got %0d expected %0d", rsp_ch.out_row,
                                       want.row));
            if (rsp_ch.out_col !== want.col)
                report_error($sformatf("out_col got %0d expected %0d", rsp_ch.out_col,
                                       want.col));
            if (rsp_ch.out_value !== want.value)
                report_error($sformatf("out_value at (%0d,%0d) got %0d expected %0d",
                                       want.row, want.col, rsp_ch.out_value, want.value));
            if (rsp_ch.last !== want.last)
                report_error($sformatf("last at (%0d,%0d) got %0d expected %0d",
                                       want.row, want.col, rsp_ch.last, want.last));
        end
    endtask

    // The checker samples just after the rising edge. At that point the signals
    // still hold the values from before the edge, and those values decide the
    // transfer.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_element();
    end

    // ------------------------------------------------------------------
    // Result receiver
    // ------------------------------------------------------------------

    function automatic int draw_wait();
        return idle_enable ? int'($urandom_range(3, 0)) : 0;
    endfunction

    // Before each result, the receiver draws a stall with draw_wait(). It lowers ready
    // for that many cycles, then holds ready high until one transfer happens.
    // When a long hold has been requested, the receiver counts it out here instead
    // of drawing a stall.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rsp_hold_cycles != 0)
            begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
            begin
                stall = draw_wait();
            end
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    // ------------------------------------------------------------------
    // Command sender
    // ------------------------------------------------------------------

    // This task sends one command. It returns right after the transfer edge. If the
    // next command follows with no gap, valid simply stays high, so valid receives
    // only one assignment in that time step.
    task automatic send_cmd(logic [2:0] op, logic [1:0] row, logic [1:0] col,
                            logic signed [31:0] val);
        int gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.row_index <= row;
        cmd_ch.col_index <= col;
        cmd_ch.value     <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predict_transform(op, row, col, val);
    endtask

    // This task stops offering commands and waits until every queued element has
    // come back. It then lets enough further cycles pass for any stray result to
    // show up.
    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Most random elements look like rotation entries, within plus or minus one.
    // The rest are full-range words, the 32-bit extremes, zero, minus one and
    // translation-sized values.
    function automatic logic signed [31:0] random_element();
        int pick;
        int unit;
        unit = 1 << rtu_pkg::FRAC_BITS;
        pick = $urandom_range(9, 0);
        if (pick < 6)
            return $urandom_range(2 * unit, 0) - unit;
        if (pick < 8)
            return $urandom;
        if (pick == 8)
        begin
            case ($urandom_range(3, 0))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                default: return -unit;
            endcase
        end
        return $urandom_range(64 * unit, 0) - 32 * unit;
    endfunction

    function automatic logic [2:0] random_run_op();
        return 3'($urandom_range(rtu_pkg::OP_DESCALE, rtu_pkg::OP_COMPOSE));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // This test writes every element of both transforms, so that the later runs
    // read only defined entries. A holds saturating extremes in its rotation part
    // and in its translation. B is a plain rotation with a translation.
    task automatic test_load_matrices();
        int r;
        int c;
        for (r = 0; r < rtu_pkg::N_ROWS; r++)
        begin
            for (c = 0; c <= rtu_pkg::TRANS_COL; c++)
            begin
                send_cmd(rtu_pkg::OP_LOAD_A, 2'(r), 2'(c), DIRECTED_A[at(r, c)]);
                send_cmd(rtu_pkg::OP_LOAD_B, 2'(r), 2'(c), DIRECTED_B[at(r, c)]);
            end
        end
    endtask

    // This test runs each run operation once and descale twice. The row and column
    // fields of run commands take varied values, up to their maximum, since the block
    // must ignore them. Descale is run with both extreme scale factors.
    task automatic test_each_operation();
        send_cmd(rtu_pkg::OP_COMPOSE, 2'b11, 2'b11, 32'sh0000_0000);
        send_cmd(rtu_pkg::OP_INVERSE, 2'b11, 2'b11, 32'shFFFF_FFFF);
        send_cmd(rtu_pkg::OP_DETERMINANT, 2'b00, 2'b00, 32'sh0000_0000);
        send_cmd(rtu_pkg::OP_DESCALE, 2'b01, 2'b10, 32'sh8000_0000);
        send_cmd(rtu_pkg::OP_DESCALE, 2'b10, 2'b01, 32'sh7FFF_FFFF);
    endtask

    // This test covers the commands that the block drops: a load aimed at row 3, and
    // the two undefined operation codes. The determinant that follows shows that A
    // was left alone.
    task automatic test_ignored_items();
        send_cmd(rtu_pkg::OP_LOAD_A, 2'b11, 2'b10, 32'sh1234_5678);
        send_cmd(OP_RESERVED_LO, 2'b11, 2'b11, 32'shFFFF_FFFF);
        send_cmd(OP_RESERVED_HI, 2'b00, 2'b00, 32'sh8000_0000);
        send_cmd(rtu_pkg::OP_DETERMINANT, 2'b11, 2'b11, 32'sh0000_0000);
    endtask

    // In this test, the receiver stalls for a long stretch while run commands keep
    // arriving back to back. The output register and the pipeline fill up, and
    // cmd.ready has to drop until the stall ends.
    task automatic test_backpressure();
        int k;
        idle_enable     = 1'b0;
        rsp_hold_cycles = HOLD_CYCLES;
        for (k = 0; k < 6; k++)
            send_cmd(random_run_op(), 2'($urandom), 2'($urandom), random_element());
        idle_enable = 1'b1;
    endtask

    // This test sends random traffic. Most of it is a burst of loads followed by one
    // run command. The rest is arbitrary commands with arbitrary fields. Stretches
    // without idle cycles come and go at random.
    task automatic test_random_traffic();
        int         placed;
        int         n_loads;
        int         k;
        logic [2:0] op;
        logic [1:0] row;
        placed = 0;
        while (placed < RANDOM_ITEMS)
        begin
            if ($urandom_range(39, 0) == 0)
                idle_enable = !idle_enable;
            if ($urandom_range(9, 0) < 7)
            begin
                n_loads = $urandom_range(6, 0);
                for (k = 0; k < n_loads; k++)
                begin
                    op = $urandom_range(1, 0) ? rtu_pkg::OP_LOAD_B : rtu_pkg::OP_LOAD_A;
                    send_cmd(op, 2'($urandom_range(rtu_pkg::LAST_ROW, 0)),
                             2'($urandom_range(rtu_pkg::TRANS_COL, 0)), random_element());
                end
                send_cmd(random_run_op(), 2'($urandom), 2'($urandom), random_element());
                placed += n_loads + 1;
            end
            else
            begin
                op  = 3'($urandom);
                row = 2'($urandom);
                send_cmd(op, row, 2'($urandom), $urandom);
                // Only commands that the block acts on count toward the total.
                if (op <= rtu_pkg::OP_DESCALE
                    && !(op <= rtu_pkg::OP_LOAD_B && row > rtu_pkg::LAST_ROW))
                    placed++;
            end
        end
        idle_enable = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        error_count      = 0;
        idle_enable      = 1'b1;
        rsp_hold_cycles  = 0;
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= rtu_pkg::OP_LOAD_A;
        cmd_ch.row_index <= 2'b00;
        cmd_ch.col_index <= 2'b00;
        cmd_ch.value     <= 32'sh0000_0000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_load_matrices();
        test_each_operation();
        wait_for_drain();
        test_ignored_items();
        wait_for_drain();
        test_backpressure();
        wait_for_drain();
        test_random_traffic();
        wait_for_drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
